[hdl/srs_pkg.sv]
`default_nettype none

package srs_pkg;

  localparam int STEP_BITS_DEF = 10;

  localparam int CMD_W   = 1;
  localparam int COUNT_W = 11;
  localparam int DELAY_W = 8;
  localparam int TPU_W   = 5;
  localparam int POS_W   = 12;
  localparam int COIL_W  = 6;
  localparam int TICK_W  = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_UNIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV  = 2'd3;

  localparam logic [DELAY_W-1:0] MAX_DELAY_RST      = 8'd15;
  localparam logic [DELAY_W-1:0] MIN_DELAY_RST      = 8'd7;
  localparam logic [TPU_W-1:0]   TICKS_PER_UNIT_RST = 5'd4;
  localparam logic [POS_W-1:0]   STEPS_PER_REV_RST  = 12'd200;

  localparam logic [CMD_W-1:0] CMD_MOVE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd3;

  localparam logic [COIL_W-1:0] COIL_TABLE [4] = '{6'h36, 6'h2E, 6'h2D, 6'h35};

  typedef struct packed {
    logic [DELAY_W-1:0] max_delay;
    logic [DELAY_W-1:0] min_delay;
    logic [TPU_W-1:0]   ticks_per_unit;
    logic [POS_W-1:0]   steps_per_rev;
  } srs_cfg_t;

  typedef struct packed {
    logic [COIL_W-1:0] coil_pattern;
    logic [POS_W-1:0]  position;
    logic              busy_res;
    logic              stepped;
    logic              done_res;
    logic              rejected;
  } srs_res_t;

  typedef struct packed {
    logic [1:0]       phase;
    logic [POS_W-1:0] pos;
  } srs_move_t;

  function automatic srs_move_t take_step(input logic [1:0] dir, input logic [1:0] phase,
                                          input logic [POS_W-1:0] pos,
                                          input logic [POS_W-1:0] spr_raw);
    logic [POS_W-1:0] spr;
    logic [POS_W:0]   inc;
    srs_move_t        m;
    spr = (spr_raw == '0) ? POS_W'(1) : spr_raw;
    inc = {1'b0, pos} + (POS_W+1)'(1);
    m.phase = phase;
    m.pos   = pos;
    if (dir == DIR_POS) begin
      m.phase = phase + 2'd1;
      if (pos == '0 || pos >= spr) begin
        m.pos = spr - POS_W'(1);
      end else begin
        m.pos = pos - POS_W'(1);
      end
    end else if (dir == DIR_NEG) begin
      m.phase = phase + 2'd3;
      if (inc >= {1'b0, spr}) begin
        m.pos = '0;
      end else begin
        m.pos = inc[POS_W-1:0];
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[hdl/stepper_ramp_sequencer.sv]
// Trapezoidal-ramp sequencer for a 4-phase stepper motor.
// Input channel (in_valid/in_stall): in_cmd selects a move (in_step_count,
// signed, sign gives direction) or one timer tick. Each item yields exactly
// one result item on the output channel (out_valid/out_stall) carrying the
// coil drive, the wrapped position and the busy/stepped/done/rejected flags.
// Path: an accepted item goes into the input register, then into the result
// register (the whole state update lies in between); out_valid marks a loaded result.
// Throughput: one item per cycle while the output is not stalled; the state
// update is a single pass of compare, add and an 8x5 multiply between the input
// and result registers. The input register keeps taking items while a result
// waits, as long as the result register is freed in the same cycle.
// Stall: a stalled result holds in the result register; the input register
// then holds its item and in_stall rises until the result is taken.
// Configuration (cfg_we/cfg_index/cfg_wdata) must be written only while idle; the block itself does not enforce this.
// Reset (rst_n low, synchronous): pipeline empty, registers back to their
// defaults (15, 7, 4, 200), phase and position zero, no move in progress.
`default_nettype none

module stepper_ramp_sequencer
  import srs_pkg::*;
#(
  parameter int STEP_BITS = STEP_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [CMD_W-1:0]          in_cmd,
  input  wire logic signed [COUNT_W-1:0] in_step_count,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [COIL_W-1:0]              out_coil_pattern,
  output logic [POS_W-1:0]               out_position,
  output logic                           out_busy_res,
  output logic                           out_stepped,
  output logic                           out_done_res,
  output logic                           out_rejected,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_wdata
);

  logic                      in_valid_r;
  logic [CMD_W-1:0]          cmd_r;
  logic signed [COUNT_W-1:0] count_r;
  logic                      out_valid_r;
  srs_res_t                  res_r;
  srs_res_t                  res;
  srs_cfg_t                  cfg;
  logic                      adv;
  logic                      in_fire;

  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_fire  = in_valid && !in_stall;

  srs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  srs_core #(
    .STEP_BITS (STEP_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (adv),
    .cmd        (cmd_r),
    .step_count (count_r),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_cmd;
      count_r <= in_step_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coil_pattern = res_r.coil_pattern;
  assign out_position     = res_r.position;
  assign out_busy_res     = res_r.busy_res;
  assign out_stepped      = res_r.stepped;
  assign out_done_res     = res_r.done_res;
  assign out_rejected     = res_r.rejected;

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.done_res |-> !res_r.busy_res)
    else $error("completed move still reported busy");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.rejected |-> res_r.busy_res && !res_r.stepped && !res_r.done_res)
    else $error("rejected move changed the drive");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(cmd_r) && $stable(count_r))
    else $error("held input item lost");
`endif

endmodule

`default_nettype wire

[hdl/srs_cfg.sv]
`default_nettype none

module srs_cfg
  import srs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output srs_cfg_t                   cfg
);

  srs_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_delay      <= MAX_DELAY_RST;
      cfg_r.min_delay      <= MIN_DELAY_RST;
      cfg_r.ticks_per_unit <= TICKS_PER_UNIT_RST;
      cfg_r.steps_per_rev  <= STEPS_PER_REV_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_DELAY:      cfg_r.max_delay      <= cfg_wdata[DELAY_W-1:0];
        REG_MIN_DELAY:      cfg_r.min_delay      <= cfg_wdata[DELAY_W-1:0];
        REG_TICKS_PER_UNIT: cfg_r.ticks_per_unit <= cfg_wdata[TPU_W-1:0];
        REG_STEPS_PER_REV:  cfg_r.steps_per_rev  <= cfg_wdata[POS_W-1:0];
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[hdl/srs_core.sv]
`default_nettype none

module srs_core
  import srs_pkg::*;
#(
  parameter int STEP_BITS = STEP_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      fire,
  input  wire logic [CMD_W-1:0]          cmd,
  input  wire logic signed [COUNT_W-1:0] step_count,
  input  srs_cfg_t                       cfg,
  output srs_res_t                       res
);

  localparam int CW = (STEP_BITS > COUNT_W) ? STEP_BITS : COUNT_W;
  localparam int RW = ((STEP_BITS > DELAY_W + 1) ? STEP_BITS : DELAY_W + 1) + 1;
  localparam int PW = DELAY_W + TPU_W;

  logic [1:0]           phase_r, phase_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [STEP_BITS-1:0] total_r, total_nxt;
  logic [STEP_BITS-1:0] stepn_r, stepn_nxt;
  logic [DELAY_W-1:0]   cur_r, cur_nxt;
  logic [DELAY_W-1:0]   floor_r, floor_nxt;
  logic [DELAY_W-1:0]   span_r, span_nxt;
  logic [TICK_W-1:0]    tick_r, tick_nxt;
  logic [1:0]           dir_r, dir_nxt;
  logic                 moving_r, moving_nxt;

  logic [COUNT_W-1:0]   raw;
  logic [COUNT_W-1:0]   mag11;
  logic [CW-1:0]        mag_c;
  logic [CW-1:0]        cap;
  logic [STEP_BITS-1:0] mag;
  logic [RW-1:0]        half_w;
  logic [DELAY_W-1:0]   half8;
  logic [DELAY_W-1:0]   fe;
  logic [DELAY_W-1:0]   span0;
  logic                 short_move;
  logic [DELAY_W-1:0]   floor_s;
  logic [DELAY_W-1:0]   span_s;
  logic [1:0]           dir_s;
  srs_move_t            mv_start;
  srs_move_t            mv_tick;
  logic [PW-1:0]        prod;
  logic [TICK_W-1:0]    target;
  logic [TICK_W-1:0]    tick_inc;
  logic [STEP_BITS-1:0] stepn_inc;
  logic                 stepped, done, rejected;

  function automatic logic [DELAY_W-1:0] plan(input logic [STEP_BITS-1:0] total,
                                              input logic [STEP_BITS-1:0] stepn,
                                              input logic [DELAY_W-1:0] cur,
                                              input logic [DELAY_W-1:0] flr,
                                              input logic [DELAY_W-1:0] span,
                                              input logic [DELAY_W-1:0] maxd);
    logic [RW-1:0]      rem;
    logic [DELAY_W-1:0] d;
    rem = RW'(total) - RW'(stepn) - RW'(1);
    if (rem > RW'(span) + RW'(1)) begin
      d = (cur > flr) ? cur - DELAY_W'(1) : flr;
    end else begin
      d = (cur < maxd) ? cur + DELAY_W'(1) : maxd;
    end
    return d;
  endfunction

  always_comb begin
    raw   = step_count;
    mag11 = raw[COUNT_W-1] ? (COUNT_W'(0) - raw) : raw;
    mag_c = CW'(mag11);
    cap   = CW'({STEP_BITS{1'b1}});
    mag   = (mag_c > cap) ? cap[STEP_BITS-1:0] : mag_c[STEP_BITS-1:0];
    half_w = RW'(mag) >> 1;
    half8  = half_w[DELAY_W-1:0];
    fe     = (cfg.min_delay < cfg.max_delay) ? cfg.min_delay : cfg.max_delay;
    span0  = cfg.max_delay - fe;
    short_move = RW'(mag) < RW'({span0, 1'b0});
    floor_s = short_move ? cfg.max_delay - half8 : fe;
    span_s  = short_move ? half8 : span0;
    if (raw == '0) begin
      dir_s = DIR_NONE;
    end else if (raw[COUNT_W-1]) begin
      dir_s = DIR_NEG;
    end else begin
      dir_s = DIR_POS;
    end
    mv_start = take_step(dir_s, phase_r, pos_r, cfg.steps_per_rev);
    mv_tick  = take_step(dir_r, phase_r, pos_r, cfg.steps_per_rev);

    prod = PW'(cur_r) * PW'(cfg.ticks_per_unit);
    if (prod > PW'({TICK_W{1'b1}})) begin
      target = {TICK_W{1'b1}};
    end else if (prod == '0) begin
      target = TICK_W'(1);
    end else begin
      target = prod[TICK_W-1:0];
    end
    tick_inc  = (tick_r == {TICK_W{1'b1}}) ? tick_r : tick_r + TICK_W'(1);
    stepn_inc = stepn_r + STEP_BITS'(1);

    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    total_nxt  = total_r;
    stepn_nxt  = stepn_r;
    cur_nxt    = cur_r;
    floor_nxt  = floor_r;
    span_nxt   = span_r;
    tick_nxt   = tick_r;
    dir_nxt    = dir_r;
    moving_nxt = moving_r;
    stepped    = 1'b0;
    done       = 1'b0;
    rejected   = 1'b0;

    if (cmd == CMD_MOVE) begin
      if (moving_r) begin
        rejected = 1'b1;
      end else begin
        floor_nxt = floor_s;
        span_nxt  = span_s;
        total_nxt = mag;
        tick_nxt  = '0;
        cur_nxt   = cfg.max_delay;
        stepn_nxt = '0;
        if (dir_s != DIR_NONE) begin
          phase_nxt = mv_start.phase;
          pos_nxt   = mv_start.pos;
          stepped   = 1'b1;
          stepn_nxt = STEP_BITS'(1);
        end
        if (mag <= STEP_BITS'(1)) begin
          moving_nxt = 1'b0;
          dir_nxt    = DIR_NONE;
          done       = 1'b1;
        end else begin
          moving_nxt = 1'b1;
          dir_nxt    = dir_s;
          cur_nxt    = plan(mag, STEP_BITS'(1), cfg.max_delay, floor_s, span_s,
                            cfg.max_delay);
        end
      end
    end else if (moving_r) begin
      if (tick_inc >= target) begin
        phase_nxt = mv_tick.phase;
        pos_nxt   = mv_tick.pos;
        stepped   = 1'b1;
        stepn_nxt = stepn_inc;
        tick_nxt  = '0;
        if (stepn_inc >= total_r) begin
          moving_nxt = 1'b0;
          dir_nxt    = DIR_NONE;
          done       = 1'b1;
        end else begin
          cur_nxt = plan(total_r, stepn_inc, cur_r, floor_r, span_r, cfg.max_delay);
        end
      end else begin
        tick_nxt = tick_inc;
      end
    end

    res.coil_pattern = COIL_TABLE[phase_nxt];
    res.position     = pos_nxt;
    res.busy_res     = moving_nxt;
    res.stepped      = stepped;
    res.done_res     = done;
    res.rejected     = rejected;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      pos_r    <= '0;
      total_r  <= '0;
      stepn_r  <= '0;
      cur_r    <= MAX_DELAY_RST;
      floor_r  <= MIN_DELAY_RST;
      span_r   <= '0;
      tick_r   <= '0;
      dir_r    <= DIR_NONE;
      moving_r <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      total_r  <= total_nxt;
      stepn_r  <= stepn_nxt;
      cur_r    <= cur_nxt;
      floor_r  <= floor_nxt;
      span_r   <= span_nxt;
      tick_r   <= tick_nxt;
      dir_r    <= dir_nxt;
      moving_r <= moving_nxt;
    end
  end

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
  import srs_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int unsigned STEP_CAP = 1023;
  localparam int unsigned WAIT_CAP = 4095;
  localparam logic [COIL_W-1:0] PHASE_COILS [4] = '{6'h36, 6'h2E, 6'h2D, 6'h35};

  typedef struct {
    logic [CMD_W-1:0]          cmd;
    logic signed [COUNT_W-1:0] count;
  } motion_item_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [CMD_W-1:0]          in_cmd = CMD_TICK;
  logic signed [COUNT_W-1:0] in_step_count = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [COIL_W-1:0]         out_coil_pattern;
  logic [POS_W-1:0]          out_position;
  logic                      out_busy_res;
  logic                      out_stepped;
  logic                      out_done_res;
  logic                      out_rejected;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_MAX_DELAY;
  logic [CFG_DATA_W-1:0]     cfg_wdata = '0;

  stepper_ramp_sequencer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_step_count    (in_step_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_coil_pattern (out_coil_pattern),
    .out_position     (out_position),
    .out_busy_res     (out_busy_res),
    .out_stepped      (out_stepped),
    .out_done_res     (out_done_res),
    .out_rejected     (out_rejected),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // motor shadow: configuration and state
  logic [DELAY_W-1:0] m_max_delay, m_min_delay;
  logic [TPU_W-1:0]   m_tpu;
  logic [POS_W-1:0]   m_spr;
  logic [1:0]         m_phase, m_dir;
  logic [POS_W-1:0]   m_pos;
  logic [9:0]         m_total, m_step_no;
  logic [DELAY_W-1:0] m_delay, m_floor, m_span;
  logic [TICK_W-1:0]  m_ticks;
  logic               m_moving = 1'b0;

  motion_item_t pending_q [$];
  srs_res_t     motor_expect_q [$];
  motion_item_t cur;
  motion_item_t drv_item;
  srs_res_t     want, got;

  event mon_done;
  bit   in_taken = 1'b0;
  bit   idle_on = 1'b1;
  int   in_gap = 0;
  int   out_hold = 0;
  int   n_cycles = 0;
  int   n_errors = 0;
  int   n_pushed = 0;
  int   n_taken = 0;
  int   n_checked = 0;
  int   n_moves = 0;
  int   n_rejects = 0;
  int   n_steps = 0;
  int   n_settings = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic reset_motor();
    m_max_delay = MAX_DELAY_RST;
    m_min_delay = MIN_DELAY_RST;
    m_tpu       = TICKS_PER_UNIT_RST;
    m_spr       = STEPS_PER_REV_RST;
    m_phase     = '0;
    m_pos       = '0;
    m_total     = '0;
    m_step_no   = '0;
    m_delay     = MAX_DELAY_RST;
    m_floor     = MIN_DELAY_RST;
    m_span      = '0;
    m_ticks     = '0;
    m_dir       = DIR_NONE;
    m_moving    = 1'b0;
  endtask

  task automatic step_rotor();
    int unsigned spr, pos;
    spr = (m_spr == '0) ? 1 : m_spr;
    pos = m_pos;
    if (m_dir == DIR_POS) begin
      m_phase = m_phase + 2'd1;
      if (pos == 0 || pos >= spr) pos = spr - 1;
      else pos = pos - 1;
    end else if (m_dir == DIR_NEG) begin
      m_phase = m_phase + 2'd3;
      pos = pos + 1;
      if (pos >= spr) pos = 0;
    end
    m_pos = POS_W'(pos);
  endtask

  task automatic next_delay();
    int unsigned left;
    left = m_total - (m_step_no + 1);
    if (left > m_span + 1) begin
      m_delay = (m_delay > m_floor) ? m_delay - DELAY_W'(1) : m_floor;
    end else begin
      m_delay = (m_delay < m_max_delay) ? m_delay + DELAY_W'(1) : m_max_delay;
    end
  endtask

  task automatic advance_motor(input motion_item_t it, output srs_res_t r);
    logic [COUNT_W-1:0] raw;
    int unsigned        mag, fe, target;
    logic               stepped, done, rej;
    stepped = 1'b0;
    done    = 1'b0;
    rej     = 1'b0;
    if (it.cmd == CMD_MOVE) begin
      if (m_moving) begin
        rej = 1'b1;
      end else begin
        raw = it.count;
        mag = raw[COUNT_W-1] ? 2048 - raw : raw;
        if (mag > STEP_CAP) mag = STEP_CAP;
        m_dir = (raw == '0) ? DIR_NONE : (raw[COUNT_W-1] ? DIR_NEG : DIR_POS);
        fe = (m_min_delay < m_max_delay) ? m_min_delay : m_max_delay;
        m_floor = DELAY_W'(fe);
        m_span  = m_max_delay - DELAY_W'(fe);
        if (mag < 2 * m_span) begin
          m_floor = m_max_delay - DELAY_W'(mag / 2);
          m_span  = DELAY_W'(mag / 2);
        end
        m_delay   = m_max_delay;
        m_total   = 10'(mag);
        m_step_no = '0;
        m_ticks   = '0;
        if (m_dir != DIR_NONE) begin
          step_rotor();
          stepped   = 1'b1;
          m_step_no = 10'd1;
        end
        if (m_total <= 1) begin
          m_moving = 1'b0;
          m_dir    = DIR_NONE;
          done     = 1'b1;
        end else begin
          m_moving = 1'b1;
          next_delay();
        end
      end
    end else if (m_moving) begin
      target = m_delay * m_tpu;
      if (target > WAIT_CAP) target = WAIT_CAP;
      if (target < 1) target = 1;
      if (m_ticks < WAIT_CAP) m_ticks = m_ticks + TICK_W'(1);
      if (m_ticks >= target) begin
        step_rotor();
        stepped   = 1'b1;
        m_step_no = m_step_no + 10'd1;
        m_ticks   = '0;
        if (m_step_no >= m_total) begin
          m_moving = 1'b0;
          m_dir    = DIR_NONE;
          done     = 1'b1;
        end else begin
          next_delay();
        end
      end
    end
    r.coil_pattern = PHASE_COILS[m_phase];
    r.position     = m_pos;
    r.busy_res     = m_moving;
    r.stepped      = stepped;
    r.done_res     = done;
    r.rejected     = rej;
  endtask

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    n_errors++;
    $display("result %0d: %s is %0h, want %0h", n_checked, what, got_v, want_v);
  endtask

  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (!rst_n) begin
      reset_motor();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_DELAY:      m_max_delay = cfg_wdata[DELAY_W-1:0];
          REG_MIN_DELAY:      m_min_delay = cfg_wdata[DELAY_W-1:0];
          REG_TICKS_PER_UNIT: m_tpu = cfg_wdata[TPU_W-1:0];
          REG_STEPS_PER_REV:  m_spr = cfg_wdata[POS_W-1:0];
          default: ;
        endcase
      end
      if (in_taken) begin
        cur.cmd   = in_cmd;
        cur.count = in_step_count;
        advance_motor(cur, want);
        motor_expect_q.push_back(want);
        n_taken++;
        if (cur.cmd == CMD_MOVE) n_moves++;
        if (want.rejected) n_rejects++;
        if (want.stepped) n_steps++;
      end
      if (out_valid && !out_stall) begin
        got.coil_pattern = out_coil_pattern;
        got.position     = out_position;
        got.busy_res     = out_busy_res;
        got.stepped      = out_stepped;
        got.done_res     = out_done_res;
        got.rejected     = out_rejected;
        if (motor_expect_q.size() == 0) begin
          report_mismatch("item with nothing pending", 1, 0);
        end else begin
          want = motor_expect_q.pop_front();
          if (got.coil_pattern !== want.coil_pattern)
            report_mismatch("coil_pattern", got.coil_pattern, want.coil_pattern);
          if (got.position !== want.position)
            report_mismatch("position", got.position, want.position);
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
          if (got.stepped !== want.stepped)
            report_mismatch("stepped", got.stepped, want.stepped);
          if (got.done_res !== want.done_res)
            report_mismatch("done_res", got.done_res, want.done_res);
          if (got.rejected !== want.rejected)
            report_mismatch("rejected", got.rejected, want.rejected);
        end
        n_checked++;
      end
    end
    -> mon_done;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pending_q.size() != 0) begin
        drv_item = pending_q.pop_front();
        in_cmd        <= drv_item.cmd;
        in_step_count <= drv_item.count;
        in_valid      <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
      if (idle_on && $urandom_range(0, 11) == 0) out_hold = $urandom_range(1, 18);
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_item(input logic [CMD_W-1:0] cmd, input int count);
    motion_item_t it;
    it.cmd   = cmd;
    it.count = COUNT_W'(count);
    pending_q.push_back(it);
    n_pushed++;
  endtask

  task automatic push_tick();
    push_item(CMD_TICK, int'($urandom_range(0, 2047)) - 1024);
  endtask

  // keep ticks (and, if noisy, stray moves) flowing until the move in progress completes
  task automatic wait_move_done(input bit noisy);
    int mark;
    mark = n_pushed;
    while (n_taken < mark) begin
      if (pending_q.size() < 2) push_tick();
      @(mon_done);
    end
    while (m_moving) begin
      if (pending_q.size() < 3) begin
        if (noisy && $urandom_range(0, 24) == 0) begin
          push_item(CMD_MOVE, int'($urandom_range(0, 80)) - 40);
        end else begin
          push_tick();
        end
      end
      @(mon_done);
    end
  endtask

  task automatic run_move(input int count, input bit noisy);
    push_item(CMD_MOVE, count);
    wait_move_done(noisy);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || motor_expect_q.size() != 0) @(mon_done);
    repeat (4) @(mon_done);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(input int max_d, input int min_d, input int tpu, input int spr);
    drain();
    set_reg(REG_MAX_DELAY, max_d);
    set_reg(REG_MIN_DELAY, min_d);
    set_reg(REG_TICKS_PER_UNIT, tpu);
    set_reg(REG_STEPS_PER_REV, spr);
    n_settings++;
  endtask

  initial begin
    int start, max_d, min_d, mag;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    push_tick();
    run_move(0, 1'b0);
    run_move(1, 1'b0);
    run_move(-1, 1'b0);
    push_item(CMD_MOVE, 3);
    push_item(CMD_MOVE, -7);
    wait_move_done(1'b0);
    push_tick();
    run_move(-2, 1'b0);

    configure(0, 0, 0, 4095);
    run_move(20, 1'b0);
    run_move(-20, 1'b0);

    configure(3, 9, 1, 5);
    run_move(6, 1'b0);
    run_move(-8, 1'b0);

    configure(4, 1, 1, 0);
    run_move(5, 1'b0);
    run_move(-5, 1'b0);

    for (int p = 0; p < 4; p++) begin
      max_d = $urandom_range(1, 8);
      min_d = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : $urandom_range(1, max_d);
      configure(max_d, min_d, $urandom_range(1, 2),
                ($urandom_range(0, 2) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 4095));
      idle_on = (p < 3);
      start = n_pushed;
      while (n_pushed - start < 40) begin
        mag = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(0, 40);
        run_move($urandom_range(0, 1) ? -mag : mag, 1'b1);
      end
    end

    // long wait with a saturated count: the move stays in progress to the end
    wait_move_done(1'b0);
    configure(255, 255, 31, 4095);
    push_item(CMD_MOVE, -1024);
    repeat (40) push_tick();

    drain();
    repeat (8) @(mon_done);
    $display("%0d items in (%0d moves, %0d rejected), %0d steps, %0d results checked",
             n_taken, n_moves, n_rejects, n_steps, n_checked);
    $display("%0d register settings incl. zero wait, long wait, flat ramp and wrap cases",
             n_settings);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
